// ----- rtl/hhpd_pkg.sv -----
package hhpd_pkg;

    localparam int OP_W      = 2;
    localparam int HEADING_W = 12;
    localparam int CMD_W     = 3;
    localparam int SPEED_W   = 8;
    localparam int GAIN_W    = 16;
    localparam int TOL_W     = 11;
    localparam int ERR_W     = 12;
    localparam int SUM_W     = 11;
    localparam int DELTA_W   = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int GAIN_FRACTION_BITS = 8;

    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W = GAIN_W + 1 + DELTA_W;
    localparam int TOTAL_W  = 32;

    localparam logic signed [DELTA_W-1:0] HALF_TURN = 13'sd1800;
    localparam logic signed [DELTA_W-1:0] FULL_TURN = 13'sd3600;
    localparam logic signed [DELTA_W-1:0] SUM_LIMIT = 13'sd1000;
    localparam logic signed [TOTAL_W-1:0] CORR_LIMIT = 32'sd100;
    localparam logic signed [TOTAL_W-1:0] TRUNC_BIAS =
        TOTAL_W'((64'sd1 <<< GAIN_FRACTION_BITS) - 64'sd1);

    typedef enum logic [OP_W-1:0] {
        OP_DRIVE = 2'd0,
        OP_TICK  = 2'd1,
        OP_TURN  = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_SPEEDS = 3'd0,
        CMD_RIGHT      = 3'd1,
        CMD_LEFT       = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_NO_CHANGE  = 3'd4
    } t_motor_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_CRUISE    = 3'd3,
        CFG_FLOOR     = 3'd4,
        CFG_CEILING   = 3'd5,
        CFG_SPIN      = 3'd6,
        CFG_TOLERANCE = 3'd7
    } t_cfg_idx;

endpackage

// ----- rtl/hhpd_in_if.sv -----
interface hhpd_in_if;
    logic                               valid;
    logic                               ready;
    logic [hhpd_pkg::OP_W-1:0]          operation;
    logic [hhpd_pkg::HEADING_W-1:0]     current_heading;
    logic [hhpd_pkg::HEADING_W-1:0]     new_target;

    modport source (output valid, operation, current_heading, new_target, input ready);
    modport sink   (input valid, operation, current_heading, new_target, output ready);
endinterface

// ----- rtl/hhpd_out_if.sv -----
interface hhpd_out_if;
    logic                               valid;
    logic                               ready;
    logic [hhpd_pkg::CMD_W-1:0]         motor_command;
    logic [hhpd_pkg::SPEED_W-1:0]       left_speed;
    logic [hhpd_pkg::SPEED_W-1:0]       right_speed;
    logic                               turn_done;
    logic                               is_moving;
    logic                               is_turning;

    modport source (output valid, motor_command, left_speed, right_speed, turn_done,
                    is_moving, is_turning, input ready);
    modport sink   (input valid, motor_command, left_speed, right_speed, turn_done,
                    is_moving, is_turning, output ready);
endinterface

// ----- rtl/heading_hold_pid_drive.sv -----
// Heading-hold controller for a differential drive. It takes one word per clock when
// the output side does not stall and returns one result word for each, through an
// input register, a stage that wraps the heading error and updates the integral,
// previous error, target and mode state, a stage with the three gain multipliers,
// and the output register where the correction is scaled, clamped and mixed into the
// two motor speeds. The feedback of the error state in the second stage is registered
// there, so it allows one word per cycle. Configuration registers are written through
// a simple write port and must only change while no word is in flight.
module heading_hold_pid_drive (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hhpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hhpd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    hhpd_in_if.sink                           i_in,
    hhpd_out_if.source                        o_out
);

    // Configuration registers
    logic [hhpd_pkg::GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic [hhpd_pkg::SPEED_W-1:0] r_cruise, r_floor, r_ceiling, r_spin;
    logic [hhpd_pkg::TOL_W-1:0]   r_tol;

    // Controller state
    logic [hhpd_pkg::HEADING_W-1:0]   r_target, n_target;
    logic signed [hhpd_pkg::ERR_W-1:0] r_prev, n_prev;
    logic signed [hhpd_pkg::SUM_W-1:0] r_sum, n_sum;
    logic                              r_fwd, n_fwd, r_turn, n_turn;

    // Pipeline valids and handshakes
    logic r_v0, r_v1, r_v2, r_v3;
    logic rdy0, rdy1, rdy2, rdy3;
    logic fire1;

    // Stage 0: input register
    logic [hhpd_pkg::OP_W-1:0]      r_s0_op;
    logic [hhpd_pkg::HEADING_W-1:0] r_s0_heading, r_s0_goal;

    // Stage 1: error terms and command information
    logic                                r_s1_pid, n_s1_pid;
    logic                                r_s1_spin, n_s1_spin;
    logic                                r_s1_done, n_s1_done;
    logic [hhpd_pkg::CMD_W-1:0]          r_s1_cmd, n_s1_cmd;
    logic                                r_s1_moving, r_s1_turning;
    logic signed [hhpd_pkg::ERR_W-1:0]   r_s1_err;
    logic signed [hhpd_pkg::SUM_W-1:0]   r_s1_sum;
    logic signed [hhpd_pkg::DELTA_W-1:0] r_s1_dlt;

    // Stage 2: products
    logic                                 r_s2_pid, r_s2_spin, r_s2_done;
    logic [hhpd_pkg::CMD_W-1:0]           r_s2_cmd;
    logic                                 r_s2_moving, r_s2_turning;
    logic signed [hhpd_pkg::PROD_P_W-1:0] r_s2_pp;
    logic signed [hhpd_pkg::PROD_I_W-1:0] r_s2_pi;
    logic signed [hhpd_pkg::PROD_D_W-1:0] r_s2_pd;

    // Stage 3: output register
    logic [hhpd_pkg::CMD_W-1:0]   r_cmd;
    logic [hhpd_pkg::SPEED_W-1:0] r_left, r_right;
    logic                         r_done, r_moving, r_turning;

    // Combinational intermediates of stage 1
    logic [hhpd_pkg::HEADING_W-1:0]      goal_sel;
    logic signed [hhpd_pkg::DELTA_W-1:0] diff, wrapped, sum_wide, dlt;
    logic signed [hhpd_pkg::ERR_W-1:0]   err;
    logic signed [hhpd_pkg::SUM_W-1:0]   sum_clamped;
    logic [hhpd_pkg::ERR_W-1:0]          mag;
    logic                                within_tol;

    // Combinational intermediates of stage 3
    logic signed [hhpd_pkg::TOTAL_W-1:0] total, biased, scaled;
    logic signed [hhpd_pkg::SPEED_W-1:0] corr;
    logic signed [9:0]                   cruise_s, floor_s, ceil_s, left_mix, right_mix;
    logic [hhpd_pkg::SPEED_W-1:0]        left_clamped, right_clamped;
    logic [hhpd_pkg::SPEED_W-1:0]        n_left, n_right;

    assign rdy3 = !r_v3 || o_out.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;
    assign fire1 = r_v0 && rdy1;
    assign i_in.ready = rdy0;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= 16'd256;
            r_gain_i  <= 16'd0;
            r_gain_d  <= 16'd0;
            r_cruise  <= 8'd150;
            r_floor   <= 8'd0;
            r_ceiling <= 8'd255;
            r_spin    <= 8'd120;
            r_tol     <= 11'd50;
        end else if (i_cfg_we) begin
            case (hhpd_pkg::t_cfg_idx'(i_cfg_index))
                hhpd_pkg::CFG_GAIN_P:    r_gain_p  <= i_cfg_data;
                hhpd_pkg::CFG_GAIN_I:    r_gain_i  <= i_cfg_data;
                hhpd_pkg::CFG_GAIN_D:    r_gain_d  <= i_cfg_data;
                hhpd_pkg::CFG_CRUISE:    r_cruise  <= i_cfg_data[hhpd_pkg::SPEED_W-1:0];
                hhpd_pkg::CFG_FLOOR:     r_floor   <= i_cfg_data[hhpd_pkg::SPEED_W-1:0];
                hhpd_pkg::CFG_CEILING:   r_ceiling <= i_cfg_data[hhpd_pkg::SPEED_W-1:0];
                hhpd_pkg::CFG_SPIN:      r_spin    <= i_cfg_data[hhpd_pkg::SPEED_W-1:0];
                hhpd_pkg::CFG_TOLERANCE: r_tol     <= i_cfg_data[hhpd_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1 logic: heading error, integral and mode update
    always_comb begin
        goal_sel = (hhpd_pkg::t_op'(r_s0_op) == hhpd_pkg::OP_TURN) ? r_s0_goal : r_target;
        diff = $signed({1'b0, goal_sel}) - $signed({1'b0, r_s0_heading});
        if (diff > hhpd_pkg::HALF_TURN) begin
            wrapped = diff - hhpd_pkg::FULL_TURN;
        end else if (diff <= -hhpd_pkg::HALF_TURN) begin
            wrapped = diff + hhpd_pkg::FULL_TURN;
        end else begin
            wrapped = diff;
        end
        err = wrapped[hhpd_pkg::ERR_W-1:0];

        sum_wide = hhpd_pkg::DELTA_W'(r_sum) + hhpd_pkg::DELTA_W'(err);
        if (sum_wide < -hhpd_pkg::SUM_LIMIT) begin
            sum_clamped = -hhpd_pkg::SUM_W'(hhpd_pkg::SUM_LIMIT);
        end else if (sum_wide > hhpd_pkg::SUM_LIMIT) begin
            sum_clamped = hhpd_pkg::SUM_W'(hhpd_pkg::SUM_LIMIT);
        end else begin
            sum_clamped = sum_wide[hhpd_pkg::SUM_W-1:0];
        end
        dlt = hhpd_pkg::DELTA_W'(err) - hhpd_pkg::DELTA_W'(r_prev);

        mag = err[hhpd_pkg::ERR_W-1] ? hhpd_pkg::ERR_W'(-err) : hhpd_pkg::ERR_W'(err);
        within_tol = mag < {1'b0, r_tol};

        n_target  = r_target;
        n_prev    = r_prev;
        n_sum     = r_sum;
        n_fwd     = r_fwd;
        n_turn    = r_turn;
        n_s1_pid  = 1'b0;
        n_s1_spin = 1'b0;
        n_s1_done = 1'b0;
        n_s1_cmd  = hhpd_pkg::CMD_NO_CHANGE;

        case (hhpd_pkg::t_op'(r_s0_op))
            hhpd_pkg::OP_DRIVE: begin
                n_fwd    = 1'b1;
                n_turn   = 1'b0;
                n_s1_pid = 1'b1;
                n_s1_cmd = hhpd_pkg::CMD_SET_SPEEDS;
                n_sum    = sum_clamped;
                n_prev   = err;
            end
            hhpd_pkg::OP_TICK: begin
                if (r_fwd && !r_turn) begin
                    n_s1_pid = 1'b1;
                    n_s1_cmd = hhpd_pkg::CMD_SET_SPEEDS;
                    n_sum    = sum_clamped;
                    n_prev   = err;
                end
            end
            hhpd_pkg::OP_TURN: begin
                n_target = r_s0_goal;
                n_fwd    = 1'b0;
                if (within_tol) begin
                    n_turn    = 1'b0;
                    n_s1_done = 1'b1;
                    n_s1_cmd  = hhpd_pkg::CMD_STOP;
                end else begin
                    n_turn    = 1'b1;
                    n_s1_spin = 1'b1;
                    n_s1_cmd  = (err > 0) ? hhpd_pkg::CMD_RIGHT : hhpd_pkg::CMD_LEFT;
                end
            end
            hhpd_pkg::OP_STOP: begin
                n_fwd    = 1'b0;
                n_turn   = 1'b0;
                n_prev   = '0;
                n_sum    = '0;
                n_s1_cmd = hhpd_pkg::CMD_STOP;
            end
            default: ;
        endcase
    end

    // Stage 3 logic: scale, clamp and mix
    always_comb begin
        total = hhpd_pkg::TOTAL_W'(r_s2_pp) + hhpd_pkg::TOTAL_W'(r_s2_pi)
              + hhpd_pkg::TOTAL_W'(r_s2_pd);
        // Arithmetic shift rounds toward minus infinity, so negative totals get a bias.
        biased = total[hhpd_pkg::TOTAL_W-1] ? total + hhpd_pkg::TRUNC_BIAS : total;
        scaled = biased >>> hhpd_pkg::GAIN_FRACTION_BITS;
        if (scaled > hhpd_pkg::CORR_LIMIT) begin
            corr = hhpd_pkg::SPEED_W'(hhpd_pkg::CORR_LIMIT);
        end else if (scaled < -hhpd_pkg::CORR_LIMIT) begin
            corr = -hhpd_pkg::SPEED_W'(hhpd_pkg::CORR_LIMIT);
        end else begin
            corr = scaled[hhpd_pkg::SPEED_W-1:0];
        end

        cruise_s  = $signed({2'b00, r_cruise});
        floor_s   = $signed({2'b00, r_floor});
        ceil_s    = $signed({2'b00, r_ceiling});
        left_mix  = cruise_s - 10'(corr);
        right_mix = cruise_s + 10'(corr);

        // Floor is tested first, so a floor above the ceiling wins for low values.
        if (left_mix < floor_s) begin
            left_clamped = r_floor;
        end else if (left_mix > ceil_s) begin
            left_clamped = r_ceiling;
        end else begin
            left_clamped = left_mix[hhpd_pkg::SPEED_W-1:0];
        end
        if (right_mix < floor_s) begin
            right_clamped = r_floor;
        end else if (right_mix > ceil_s) begin
            right_clamped = r_ceiling;
        end else begin
            right_clamped = right_mix[hhpd_pkg::SPEED_W-1:0];
        end

        if (r_s2_pid) begin
            n_left  = left_clamped;
            n_right = right_clamped;
        end else if (r_s2_spin) begin
            n_left  = r_spin;
            n_right = r_spin;
        end else begin
            n_left  = '0;
            n_right = '0;
        end
    end

    // Valid bits and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_target <= '0;
            r_prev   <= '0;
            r_sum    <= '0;
            r_fwd    <= 1'b0;
            r_turn   <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_in.valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (fire1) begin
                r_target <= n_target;
                r_prev   <= n_prev;
                r_sum    <= n_sum;
                r_fwd    <= n_fwd;
                r_turn   <= n_turn;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in.valid) begin
            r_s0_op      <= i_in.operation;
            r_s0_heading <= i_in.current_heading;
            r_s0_goal    <= i_in.new_target;
        end
        if (fire1) begin
            r_s1_pid     <= n_s1_pid;
            r_s1_spin    <= n_s1_spin;
            r_s1_done    <= n_s1_done;
            r_s1_cmd     <= n_s1_cmd;
            r_s1_moving  <= n_fwd || n_turn;
            r_s1_turning <= n_turn;
            r_s1_err     <= err;
            r_s1_sum     <= sum_clamped;
            r_s1_dlt     <= dlt;
        end
        if (r_v1 && rdy2) begin
            r_s2_pid     <= r_s1_pid;
            r_s2_spin    <= r_s1_spin;
            r_s2_done    <= r_s1_done;
            r_s2_cmd     <= r_s1_cmd;
            r_s2_moving  <= r_s1_moving;
            r_s2_turning <= r_s1_turning;
            r_s2_pp      <= $signed({1'b0, r_gain_p}) * r_s1_err;
            r_s2_pi      <= $signed({1'b0, r_gain_i}) * r_s1_sum;
            r_s2_pd      <= $signed({1'b0, r_gain_d}) * r_s1_dlt;
        end
        if (r_v2 && rdy3) begin
            r_cmd     <= r_s2_cmd;
            r_left    <= n_left;
            r_right   <= n_right;
            r_done    <= r_s2_done;
            r_moving  <= r_s2_moving;
            r_turning <= r_s2_turning;
        end
    end

    assign o_out.valid         = r_v3;
    assign o_out.motor_command = r_cmd;
    assign o_out.left_speed    = r_left;
    assign o_out.right_speed   = r_right;
    assign o_out.turn_done     = r_done;
    assign o_out.is_moving     = r_moving;
    assign o_out.is_turning    = r_turning;

    a_modes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fwd && r_turn))
        else $error("forward and turning modes set together");

    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum >= -11'sd1000) && (r_sum <= 11'sd1000))
        else $error("integral outside its clamp range");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire1 && hhpd_pkg::t_op'(r_s0_op) == hhpd_pkg::OP_STOP)
        |=> (r_sum == '0 && r_prev == '0 && !r_fwd && !r_turn))
        else $error("stop word did not clear the controller state");

    // A tick during a turn also reports no change, so only speeds and done are fixed.
    a_no_change_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_cmd == hhpd_pkg::CMD_NO_CHANGE)
        |-> (r_left == '0 && r_right == '0 && !r_done))
        else $error("idle tick produced speeds or turn status");

endmodule

// ----- tb/sv/heading_hold_pid_drive_check.sv -----
`timescale 1ns / 1ps

module heading_hold_pid_drive_check
    import hhpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hhpd_in_if                    i_in,
    hhpd_out_if                   i_out,
    output int                    o_fail_count,
    output int                    o_words_due
);

    localparam int CORRECTION_MAX = 100;
    localparam int INTEGRAL_MAX   = 1000;
    localparam int WHOLE_TURN     = 3600;
    localparam int HALF_CIRCLE    = 1800;

    typedef struct packed {
        t_motor_cmd         cmd;
        logic [SPEED_W-1:0] left;
        logic [SPEED_W-1:0] right;
        logic               done;
        logic               moving;
        logic               turning;
    } t_motor_word;

    logic [GAIN_W-1:0]    gain_p;
    logic [GAIN_W-1:0]    gain_i;
    logic [GAIN_W-1:0]    gain_d;
    logic [SPEED_W-1:0]   cruise;
    logic [SPEED_W-1:0]   floor_speed;
    logic [SPEED_W-1:0]   ceiling_speed;
    logic [SPEED_W-1:0]   spin;
    logic [TOL_W-1:0]     tolerance;

    logic [HEADING_W-1:0] goal_heading;
    int                   last_error;
    int                   error_total;
    logic                 forward_on;
    logic                 turning_on;

    t_motor_word          motor_words_due[$];
    int                   mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int clamp_int(int x, int lo, int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // The raw difference is folded back once, so headings above 3599 still land
    // close to the half-circle window.
    function automatic int wrapped_error(logic [HEADING_W-1:0] now_hd,
                                         logic [HEADING_W-1:0] goal_hd);
        int e;
        e = int'(goal_hd) - int'(now_hd);
        if (e > HALF_CIRCLE)
            e -= WHOLE_TURN;
        else if (e <= -HALF_CIRCLE)
            e += WHOLE_TURN;
        return e;
    endfunction

    function automatic t_motor_word pid_correct(logic [HEADING_W-1:0] now_hd);
        int          e;
        longint      total;
        longint      corr;
        int          c;
        int          left_mix;
        int          right_mix;
        t_motor_word w;
        e = wrapped_error(now_hd, goal_heading);
        error_total = clamp_int(error_total + e, -INTEGRAL_MAX, INTEGRAL_MAX);
        total = longint'(gain_p) * e + longint'(gain_i) * error_total
              + longint'(gain_d) * (e - last_error);
        last_error = e;
        // Division of a signed value truncates toward zero, as the scaling needs.
        corr = total / (longint'(1) << GAIN_FRACTION_BITS);
        if (corr > CORRECTION_MAX) corr = CORRECTION_MAX;
        if (corr < -CORRECTION_MAX) corr = -CORRECTION_MAX;
        c = int'(corr);
        left_mix  = clamp_int(int'(cruise) - c, int'(floor_speed), int'(ceiling_speed));
        right_mix = clamp_int(int'(cruise) + c, int'(floor_speed), int'(ceiling_speed));
        w.cmd     = CMD_SET_SPEEDS;
        w.left    = left_mix[SPEED_W-1:0];
        w.right   = right_mix[SPEED_W-1:0];
        w.done    = 1'b0;
        w.moving  = 1'b0;
        w.turning = 1'b0;
        return w;
    endfunction

    function automatic t_motor_word predict_motor_word(t_op op,
                                                       logic [HEADING_W-1:0] now_hd,
                                                       logic [HEADING_W-1:0] goal_hd);
        t_motor_word w;
        int          e;
        int          mag;
        w.cmd     = CMD_NO_CHANGE;
        w.left    = '0;
        w.right   = '0;
        w.done    = 1'b0;
        w.moving  = 1'b0;
        w.turning = 1'b0;
        case (op)
            OP_DRIVE: begin
                forward_on = 1'b1;
                turning_on = 1'b0;
                w = pid_correct(now_hd);
            end
            OP_TICK: begin
                if (forward_on && !turning_on)
                    w = pid_correct(now_hd);
            end
            OP_TURN: begin
                goal_heading = goal_hd;
                forward_on   = 1'b0;
                turning_on   = 1'b1;
                e   = wrapped_error(now_hd, goal_heading);
                mag = (e < 0) ? -e : e;
                if (mag < int'(tolerance)) begin
                    w.cmd      = CMD_STOP;
                    w.done     = 1'b1;
                    turning_on = 1'b0;
                end else begin
                    w.cmd   = (e > 0) ? CMD_RIGHT : CMD_LEFT;
                    w.left  = spin;
                    w.right = spin;
                end
            end
            default: begin
                w.cmd       = CMD_STOP;
                forward_on  = 1'b0;
                turning_on  = 1'b0;
                last_error  = 0;
                error_total = 0;
            end
        endcase
        w.moving  = forward_on || turning_on;
        w.turning = turning_on;
        return w;
    endfunction

    task automatic check_field(string field_name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field_name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_motor_word got;
        t_motor_word want;
        if (!i_rst_n) begin
            gain_p        = 16'd256;
            gain_i        = '0;
            gain_d        = '0;
            cruise        = 8'd150;
            floor_speed   = '0;
            ceiling_speed = 8'd255;
            spin          = 8'd120;
            tolerance     = 11'd50;
            goal_heading  = '0;
            last_error    = 0;
            error_total   = 0;
            forward_on    = 1'b0;
            turning_on    = 1'b0;
            motor_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_P:    gain_p        = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:    gain_i        = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:    gain_d        = i_cfg_data[GAIN_W-1:0];
                    CFG_CRUISE:    cruise        = i_cfg_data[SPEED_W-1:0];
                    CFG_FLOOR:     floor_speed   = i_cfg_data[SPEED_W-1:0];
                    CFG_CEILING:   ceiling_speed = i_cfg_data[SPEED_W-1:0];
                    CFG_SPIN:      spin          = i_cfg_data[SPEED_W-1:0];
                    CFG_TOLERANCE: tolerance     = i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.cmd     = t_motor_cmd'(i_out.motor_command);
                got.left    = i_out.left_speed;
                got.right   = i_out.right_speed;
                got.done    = i_out.turn_done;
                got.moving  = i_out.is_moving;
                got.turning = i_out.is_turning;
                if (motor_words_due.size() == 0) begin
                    $display("%0t: result word with nothing expected, got %p", $time, got);
                    mismatches++;
                end else begin
                    want = motor_words_due.pop_front();
                    check_field("motor_command", int'(want.cmd), int'(got.cmd));
                    check_field("left_speed", int'(want.left), int'(got.left));
                    check_field("right_speed", int'(want.right), int'(got.right));
                    check_field("turn_done", int'(want.done), int'(got.done));
                    check_field("is_moving", int'(want.moving), int'(got.moving));
                    check_field("is_turning", int'(want.turning), int'(got.turning));
                end
            end
            if (i_in.valid && i_in.ready)
                motor_words_due.push_back(predict_motor_word(t_op'(i_in.operation),
                                                             i_in.current_heading,
                                                             i_in.new_target));
        end
        o_words_due <= motor_words_due.size();
    end

endmodule

// ----- tb/sv/heading_hold_pid_drive_test.sv -----
`timescale 1ns / 1ps

module heading_hold_pid_drive_test;
    import hhpd_pkg::*;

    localparam int IDLE_LIMIT       = 2000;
    localparam int RANDOM_PER_PHASE = 120;
    localparam int PHASES           = 7;
    localparam int WHOLE_TURN_T     = 3600;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    words_due;
    bit                    calm;
    int                    ready_hold = 0;

    hhpd_in_if  in_ch ();
    hhpd_out_if out_ch ();

    always #1 clk = ~clk;

    heading_hold_pid_drive dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    heading_hold_pid_drive_check monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    // Mostly short pauses, now and then a long one, none at all in a calm phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    always @(negedge clk) begin
        if (ready_hold > 0) begin
            out_ch.ready = 1'b0;
            ready_hold--;
        end else begin
            out_ch.ready = 1'b1;
            ready_hold = pick_gap();
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                !rst_n || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_word(t_op op, int now_hd, int goal_hd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid           = 1'b1;
        in_ch.operation       = op;
        in_ch.current_heading = HEADING_W'(now_hd);
        in_ch.new_target      = HEADING_W'(goal_hd);
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Drops valid and lets every outstanding word drain before going on.
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        wait (words_due == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_regs(int gp, int gi, int gd, int cruise, int floor_spd,
                            int ceiling_spd, int spin, int tol);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_CRUISE, cruise);
        write_reg(CFG_FLOOR, floor_spd);
        write_reg(CFG_CEILING, ceiling_spd);
        write_reg(CFG_SPIN, spin);
        write_reg(CFG_TOLERANCE, tol);
    endtask

    task automatic configure(int phase);
        case (phase)
            1: set_regs($urandom_range(0, 1024), $urandom_range(0, 64), $urandom_range(0, 512),
                        $urandom_range(0, 255), $urandom_range(0, 60),
                        $urandom_range(190, 255), $urandom_range(0, 255),
                        $urandom_range(0, 200));
            2: set_regs(65535, 65535, 65535, 255, 0, 255, 255, 1800);
            3: set_regs(0, 0, 0, 0, 0, 0, 0, 0);
            4: set_regs(300, 20, 100, 128, 200, 60, 77, 1);
            5: set_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 1800));
            default: set_regs($urandom_range(64, 768), $urandom_range(1, 200),
                              $urandom_range(0, 2048), $urandom_range(60, 200),
                              $urandom_range(0, 40), $urandom_range(200, 255),
                              $urandom_range(0, 255), $urandom_range(10, 120));
        endcase
    endtask

    // Mostly drive-and-tick runs with headings near the last turn target, so the
    // integral gets time to build up, mixed with turns, stops and wild headings.
    task automatic random_run(int count, bit hold_midway);
        int aim;
        int r;
        int spread;
        int now_hd;
        int goal_hd;
        t_op op;
        aim = $urandom_range(0, 3599);
        for (int n = 0; n < count; n++) begin
            if (hold_midway && n == count / 2)
                settle();
            r = $urandom_range(0, 99);
            if (r < 12)      op = OP_DRIVE;
            else if (r < 72) op = OP_TICK;
            else if (r < 88) op = OP_TURN;
            else if (r < 95) op = OP_STOP;
            else             op = t_op'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            spread = ($urandom_range(0, 1) != 0) ? 40 : 400;
            if (r < 60)
                now_hd = (aim + WHOLE_TURN_T + $urandom_range(0, 2 * spread) - spread)
                         % WHOLE_TURN_T;
            else if (r < 92)
                now_hd = $urandom_range(0, 3599);
            else
                now_hd = $urandom_range(0, 4095);
            r = $urandom_range(0, 99);
            if (r < 25)
                goal_hd = (now_hd + WHOLE_TURN_T + $urandom_range(0, 120) - 60) % WHOLE_TURN_T;
            else if (r < 92)
                goal_hd = $urandom_range(0, 3599);
            else
                goal_hd = $urandom_range(0, 4095);
            if (op == OP_TURN)
                aim = goal_hd;
            send_word(op, now_hd, goal_hd);
        end
    endtask

    initial begin
        rst_n                 = 1'b0;
        calm                  = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        in_ch.valid           = 1'b0;
        in_ch.operation       = OP_DRIVE;
        in_ch.current_heading = '0;
        in_ch.new_target      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the reset settings.
        send_word(OP_TICK, 0, 0);
        send_word(OP_STOP, 0, 0);
        send_word(OP_DRIVE, 0, 0);
        send_word(OP_DRIVE, 3599, 0);
        send_word(OP_DRIVE, 1800, 0);
        send_word(OP_DRIVE, 1799, 0);
        send_word(OP_TICK, 4095, 0);
        send_word(OP_TICK, 30, 4095);
        send_word(OP_TURN, 0, 3599);
        send_word(OP_TICK, 0, 0);
        send_word(OP_TURN, 0, 50);
        send_word(OP_TURN, 50, 0);
        send_word(OP_TURN, 0, 0);
        send_word(OP_TURN, 0, 1800);
        send_word(OP_TURN, 1800, 0);
        send_word(OP_TURN, 0, 4095);
        send_word(OP_DRIVE, 2000, 4095);
        send_word(OP_TICK, 4095, 0);
        send_word(OP_STOP, 100, 200);
        send_word(OP_TURN, 900, 100);
        send_word(OP_STOP, 4095, 4095);
        random_run(RANDOM_PER_PHASE, 1'b0);

        for (int phase = 1; phase < PHASES; phase++) begin
            settle();
            configure(phase);
            calm = (phase == 4);
            random_run(RANDOM_PER_PHASE, phase == 1);
        end
        calm = 1'b0;

        settle();
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hhpd_pkg.sv
rtl/hhpd_in_if.sv
rtl/hhpd_out_if.sv
rtl/heading_hold_pid_drive.sv
tb/sv/heading_hold_pid_drive_check.sv
tb/sv/heading_hold_pid_drive_test.sv
